// ===== design/diseqc_message_transmitter_defines.svh =====
// Assertion macros for the DiSEqC message transmitter.
// Self-contained; taken in by files that carry concurrent assertions.
`ifndef DISEQC_MESSAGE_TRANSMITTER_DEFINES_SVH
`define DISEQC_MESSAGE_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define DSQ_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define DSQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/dsq_pkg.sv =====
// Types and constants for the DiSEqC message transmitter.
// No dependencies; imported by the sequencer, the top level and the testbench.
package dsq_pkg;

   localparam int SLOT_W   = 6;
   localparam int BYTES_W  = 3;
   localparam int BITPOS_W = 4;
   localparam int MSG_W    = 32;

   localparam logic [SLOT_W-1:0]   SLOTS_PER_BIT  = 6'd3;
   localparam logic [BITPOS_W-1:0] BITS_PER_BYTE  = 4'd9;
   localparam logic [BITPOS_W-1:0] DATA_BITS      = 4'd8;
   localparam logic [BYTES_W-1:0]  BYTES_WITH_DATA = 3'd4;
   localparam logic [BYTES_W-1:0]  BYTES_NO_DATA   = 3'd3;

   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_PRE  = 3'd1,
      PH_BITS = 3'd2,
      PH_POST = 3'd3
   } phase_type;

   typedef enum logic {
      OP_TICK  = 1'b0,
      OP_START = 1'b1
   } opcode_type;

   typedef struct packed {
      logic tone;
      logic busy_res;
      logic accepted;
      logic message_done;
   } result_type;

endpackage

// ===== design/dsq_frame_seq.sv =====
// Slot sequencer: phase, slot counter, byte shifter and parity for one message.
// Depends on dsq_pkg.
module dsq_frame_seq
   import dsq_pkg::*;
#(
   parameter int PRE_GAP_SLOTS  = 30,
   parameter int POST_GAP_SLOTS = 40
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       advance,
   input  logic       continuous_tone,
   input  logic       opcode,
   input  logic [7:0] framing_byte,
   input  logic [7:0] address_byte,
   input  logic [7:0] command_byte,
   input  logic [7:0] data_byte,
   input  logic       has_data,
   output result_type result
);

   localparam logic [SLOT_W-1:0] PRE_LOAD  = SLOT_W'(PRE_GAP_SLOTS);
   localparam logic [SLOT_W-1:0] POST_LOAD = SLOT_W'(POST_GAP_SLOTS);

   phase_type             phase_ff, phase_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [MSG_W-1:0]      msg_ff, msg_in;
   logic [BYTES_W-1:0]    bytes_ff, bytes_in;
   logic [BITPOS_W-1:0]   bitpos_ff, bitpos_in;
   logic                  parity_ff, parity_in;
   logic                  cur_ff, cur_in;
   logic                  load_bit;
   logic                  head_bit;

   always_comb begin
      phase_in  = phase_ff;
      slot_in   = slot_ff;
      msg_in    = msg_ff;
      bytes_in  = bytes_ff;
      bitpos_in = bitpos_ff;
      parity_in = parity_ff;
      cur_in    = cur_ff;
      load_bit  = 1'b0;
      head_bit  = 1'b0;
      result    = '0;

      if (opcode == OP_START) begin
         if (phase_ff == PH_IDLE) begin
            result.accepted = 1'b1;
            msg_in    = {framing_byte, address_byte, command_byte, data_byte};
            bytes_in  = has_data ? BYTES_WITH_DATA : BYTES_NO_DATA;
            bitpos_in = '0;
            parity_in = 1'b1;
            if (continuous_tone) begin
               phase_in = PH_PRE;
               slot_in  = PRE_LOAD;
            end else begin
               phase_in = PH_BITS;
               load_bit = 1'b1;
            end
         end
      end else begin
         case (phase_ff)
            PH_PRE: begin
               slot_in = slot_ff - 1'b1;
               if (slot_in == '0) begin
                  phase_in  = PH_BITS;
                  bitpos_in = '0;
                  parity_in = 1'b1;
                  load_bit  = 1'b1;
               end
            end
            PH_BITS: begin
               slot_in = slot_ff + 1'b1;
               if (slot_in >= SLOTS_PER_BIT) begin
                  bitpos_in = bitpos_ff + 1'b1;
                  if (bitpos_in >= BITS_PER_BYTE) begin
                     bitpos_in = '0;
                     parity_in = 1'b1;
                     bytes_in  = bytes_ff - 1'b1;
                  end
                  if (bytes_in == '0) begin
                     phase_in = PH_POST;
                     slot_in  = POST_LOAD;
                  end else begin
                     load_bit = 1'b1;
                  end
               end
            end
            PH_POST: begin
               slot_in = slot_ff - 1'b1;
               if (slot_in == '0) begin
                  phase_in            = PH_IDLE;
                  result.message_done = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      // data bits come off the top of the shifter; the ninth bit is parity
      if (load_bit) begin
         if (bitpos_in < DATA_BITS) begin
            head_bit  = msg_in[MSG_W-1];
            msg_in    = {msg_in[MSG_W-2:0], 1'b0};
            parity_in = parity_in ^ head_bit;
            cur_in    = head_bit;
         end else begin
            cur_in = parity_in;
         end
         slot_in = '0;
      end

      case (phase_in)
         PH_BITS:         result.tone = cur_in ? (slot_in == '0) : (slot_in < 6'd2);
         PH_PRE, PH_POST: result.tone = 1'b0;
         default:         result.tone = continuous_tone;
      endcase
      result.busy_res = (phase_in != PH_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         slot_ff   <= '0;
         msg_ff    <= '0;
         bytes_ff  <= '0;
         bitpos_ff <= '0;
         parity_ff <= 1'b1;
         cur_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         slot_ff   <= slot_in;
         msg_ff    <= msg_in;
         bytes_ff  <= bytes_in;
         bitpos_ff <= bitpos_in;
         parity_ff <= parity_in;
         cur_ff    <= cur_in;
      end
   end

endmodule

// ===== design/diseqc_message_transmitter.sv =====
// DiSEqC 1.0 message transmitter, top level: config register and result register.
// Depends on dsq_pkg, dsq_frame_seq and diseqc_message_transmitter_defines.svh.
//
// Usage: each word on the req_ channel is either a tick (one 500 us slot) or a
// start carrying framing, address, command and optional data byte. Every word
// yields exactly one rsp_ word: the tone gate level for the coming slot, busy,
// whether a start was taken and whether the post-message gap just ended.
// csr_we with csr_wdata writes continuous_tone; write it only while idle.
// The response is registered and appears in the cycle after the request is taken.
// One word is taken per cycle while req_stall is low.
// The response register is refilled in the same cycle it is drained, so req_stall
// rises only when a response is held and rsp_stall is high.
// Reset: idle, continuous tone off, no response pending.
// A stalled response holds its value until it is taken.
`include "diseqc_message_transmitter_defines.svh"

module diseqc_message_transmitter
   import dsq_pkg::*;
#(
   parameter int PRE_GAP_SLOTS  = 30,
   parameter int POST_GAP_SLOTS = 40
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic       csr_wdata,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_opcode,
   input  logic [7:0] req_framing_byte,
   input  logic [7:0] req_address_byte,
   input  logic [7:0] req_command_byte,
   input  logic [7:0] req_data_byte,
   input  logic       req_has_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_tone,
   output logic       rsp_busy_res,
   output logic       rsp_accepted,
   output logic       rsp_message_done
);

   logic       cont_tone_ff;
   logic       rsp_valid_ff;
   result_type rsp_ff;
   result_type seq_result;
   logic       advance;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign advance   = req_valid & ~req_stall;

   dsq_frame_seq #(
      .PRE_GAP_SLOTS  (PRE_GAP_SLOTS),
      .POST_GAP_SLOTS (POST_GAP_SLOTS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .advance         (advance),
      .continuous_tone (cont_tone_ff),
      .opcode          (req_opcode),
      .framing_byte    (req_framing_byte),
      .address_byte    (req_address_byte),
      .command_byte    (req_command_byte),
      .data_byte       (req_data_byte),
      .has_data        (req_has_data),
      .result          (seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cont_tone_ff <= 1'b0;
      end else if (csr_we) begin
         cont_tone_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // payload: load on every taken word, hold otherwise
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= seq_result;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_tone         = rsp_ff.tone;
   assign rsp_busy_res     = rsp_ff.busy_res;
   assign rsp_accepted     = rsp_ff.accepted;
   assign rsp_message_done = rsp_ff.message_done;

   `DSQ_ASSERT_NEXT(a_taken_gives_rsp, clock, reset, advance, rsp_valid_ff, "taken word produced no response")
   `DSQ_ASSERT_IMPL(a_accept_busy, clock, reset, rsp_valid_ff && rsp_ff.accepted, rsp_ff.busy_res, "accepted start not busy")
   `DSQ_ASSERT_IMPL(a_done_idle, clock, reset, rsp_valid_ff && rsp_ff.message_done, !rsp_ff.busy_res && !rsp_ff.accepted, "message_done while busy")

endmodule

// ===== tb/sv/dsq_tone_scoreboard_pkg.sv =====
`timescale 1ns / 1ps
// Slot-level predictor and response scoreboard for the DiSEqC transmitter.
// Depends on dsq_pkg for the phase, opcode and response types.
package dsq_tone_scoreboard_pkg;
   import dsq_pkg::*;

   localparam logic [SLOT_W-1:0] GUARD_SLOTS = 6'd30;
   localparam logic [SLOT_W-1:0] QUIET_SLOTS = 6'd40;

   class tone_scoreboard;
      bit                    cont_tone;
      phase_type             phase;
      logic [SLOT_W-1:0]     slots;
      logic [MSG_W-1:0]      shift_bits;
      logic [BYTES_W-1:0]    bytes_left;
      logic [BITPOS_W-1:0]   bit_pos;
      bit                    parity;
      bit                    cur_bit;
      result_type            expected_q[$];
      int unsigned           errors;

      function new();
         cont_tone  = 1'b0;
         phase      = PH_IDLE;
         slots      = '0;
         shift_bits = '0;
         bytes_left = '0;
         bit_pos    = '0;
         parity     = 1'b1;
         cur_bit    = 1'b0;
         errors     = 0;
      endfunction

      function void set_tone(bit v);
         cont_tone = v;
      endfunction

      // pick the next data bit, or the parity bit after eight of them
      function void load_bit();
         if (bit_pos < DATA_BITS) begin
            cur_bit    = shift_bits[MSG_W-1];
            shift_bits = shift_bits << 1;
            parity     = parity ^ cur_bit;
         end else begin
            cur_bit = parity;
         end
         slots = '0;
      endfunction

      function void start_bits();
         phase   = PH_BITS;
         bit_pos = '0;
         parity  = 1'b1;
         load_bit();
      endfunction

      function bit tone_now();
         if (phase == PH_BITS)
            return slots < (cur_bit ? 6'd1 : 6'd2);
         if (phase == PH_PRE || phase == PH_POST)
            return 1'b0;
         return cont_tone;
      endfunction

      function void note_word(opcode_type op, logic [7:0] fr, logic [7:0] ad,
                              logic [7:0] cm, logic [7:0] dt, logic hd);
         result_type want;
         want = '0;
         if (op == OP_START) begin
            // a start while busy leaves everything as it is
            if (phase == PH_IDLE) begin
               want.accepted = 1'b1;
               shift_bits    = {fr, ad, cm, dt};
               bytes_left    = hd ? BYTES_WITH_DATA : BYTES_NO_DATA;
               if (cont_tone) begin
                  phase   = PH_PRE;
                  slots   = GUARD_SLOTS;
                  bit_pos = '0;
                  parity  = 1'b1;
               end else begin
                  start_bits();
               end
            end
         end else begin
            case (phase)
               PH_PRE: begin
                  slots = slots - 1'b1;
                  if (slots == '0)
                     start_bits();
               end
               PH_BITS: begin
                  slots = slots + 1'b1;
                  if (slots >= SLOTS_PER_BIT) begin
                     bit_pos = bit_pos + 1'b1;
                     if (bit_pos >= BITS_PER_BYTE) begin
                        bit_pos    = '0;
                        parity     = 1'b1;
                        bytes_left = bytes_left - 1'b1;
                     end
                     if (bytes_left == '0) begin
                        phase = PH_POST;
                        slots = QUIET_SLOTS;
                     end else begin
                        load_bit();
                     end
                  end
               end
               PH_POST: begin
                  slots = slots - 1'b1;
                  if (slots == '0) begin
                     phase             = PH_IDLE;
                     want.message_done = 1'b1;
                  end
               end
               default: ;
            endcase
         end
         want.tone     = tone_now();
         want.busy_res = (phase != PH_IDLE);
         expected_q.push_back(want);
      endfunction

      function void check_word(result_type got);
         result_type want;
         if (expected_q.size() == 0) begin
            $error("response word with none predicted: %b", got);
            errors++;
            return;
         end
         want = expected_q.pop_front();
         if (got.tone !== want.tone) begin
            $error("tone: expected %0b, got %0b", want.tone, got.tone);
            errors++;
         end
         if (got.busy_res !== want.busy_res) begin
            $error("busy_res: expected %0b, got %0b", want.busy_res, got.busy_res);
            errors++;
         end
         if (got.accepted !== want.accepted) begin
            $error("accepted: expected %0b, got %0b", want.accepted, got.accepted);
            errors++;
         end
         if (got.message_done !== want.message_done) begin
            $error("message_done: expected %0b, got %0b",
                   want.message_done, got.message_done);
            errors++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit busy();
         return phase != PH_IDLE;
      endfunction

      function bit clean();
         if (expected_q.size() != 0)
            $error("%0d predicted response words never arrived", expected_q.size());
         return errors == 0 && expected_q.size() == 0;
      endfunction
   endclass

endpackage

// ===== tb/sv/diseqc_message_transmitter_test.sv =====
`timescale 1ns / 1ps
// Top-level test of diseqc_message_transmitter: drives ticks and starts under random
// idling and back-pressure. Depends on dsq_pkg and dsq_tone_scoreboard_pkg.
module diseqc_message_transmitter_test;
   import dsq_pkg::*;
   import dsq_tone_scoreboard_pkg::*;

   logic       clock;
   logic       reset;
   logic       csr_we;
   logic       csr_wdata;
   logic       req_valid;
   logic       req_stall;
   logic       req_opcode;
   logic [7:0] req_framing_byte;
   logic [7:0] req_address_byte;
   logic [7:0] req_command_byte;
   logic [7:0] req_data_byte;
   logic       req_has_data;
   logic       rsp_valid;
   logic       rsp_stall;
   logic       rsp_tone;
   logic       rsp_busy_res;
   logic       rsp_accepted;
   logic       rsp_message_done;

   tone_scoreboard sb = new();
   int unsigned    words_sent;
   bit             tx_burst;
   bit             rx_burst;

   diseqc_message_transmitter dut (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (req_opcode),
      .req_framing_byte (req_framing_byte),
      .req_address_byte (req_address_byte),
      .req_command_byte (req_command_byte),
      .req_data_byte    (req_data_byte),
      .req_has_data     (req_has_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_tone         (rsp_tone),
      .rsp_busy_res     (rsp_busy_res),
      .rsp_accepted     (rsp_accepted),
      .rsp_message_done (rsp_message_done)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard limit, far beyond the slowest legal run
   initial begin
      #(5_000_000);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // present one word, hold it until taken, then note it
   task automatic send_word(opcode_type op, logic [7:0] fr, logic [7:0] ad,
                            logic [7:0] cm, logic [7:0] dt, logic hd);
      int gap;
      gap = tx_burst ? 0 : $urandom_range(0, 6);
      @(negedge clock);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid        = 1'b1;
      req_opcode       = op;
      req_framing_byte = fr;
      req_address_byte = ad;
      req_command_byte = cm;
      req_data_byte    = dt;
      req_has_data     = hd;
      forever begin
         @(posedge clock);
         if (!req_stall)
            break;
      end
      sb.note_word(op, fr, ad, cm, dt, hd);
      words_sent++;
   endtask

   task automatic send_tick();
      send_word(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom_range(0, 1)));
   endtask

   task automatic send_noise_start();
      send_word(OP_START, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                1'($urandom_range(0, 1)));
   endtask

   // tick, or at the given per-mille rate send a noise start, until the gap after the message has run out
   task automatic finish_message(int noise_permille);
      while (sb.busy()) begin
         if ($urandom_range(0, 999) < noise_permille)
            send_noise_start();
         else
            send_tick();
      end
   endtask

   task automatic run_message(logic [7:0] fr, logic [7:0] ad, logic [7:0] cm,
                              logic [7:0] dt, logic hd, int noise_permille);
      send_word(OP_START, fr, ad, cm, dt, hd);
      finish_message(noise_permille);
   endtask

   // drop valid, wait for every response, then write the register
   task automatic write_tone(bit v);
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.pending() > 0)
         @(posedge clock);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = v;
      @(posedge clock);
      sb.set_tone(v);
      @(negedge clock);
      csr_we    = 1'b0;
      csr_wdata = 1'($urandom_range(0, 1));
   endtask

   // response side: random stall per word, check at the accepting edge
   initial begin : rsp_side
      int         n;
      result_type got;
      rsp_stall = 1'b0;
      forever begin
         n = rx_burst ? 0 : $urandom_range(0, 6);
         if (n > 0) begin
            @(negedge clock);
            rsp_stall = 1'b1;
            repeat (n - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_stall = 1'b0;
         forever begin
            @(posedge clock);
            if (rsp_valid)
               break;
         end
         got.tone         = rsp_tone;
         got.busy_res     = rsp_busy_res;
         got.accepted     = rsp_accepted;
         got.message_done = rsp_message_done;
         sb.check_word(got);
         if ($urandom_range(0, 199) == 0)
            rx_burst = ~rx_burst;
      end
   end

   initial begin : req_side
      int bound;
      int idle_ticks;
      reset            = 1'b1;
      csr_we           = 1'b0;
      csr_wdata        = 1'b0;
      req_valid        = 1'b0;
      req_opcode       = OP_TICK;
      req_framing_byte = '0;
      req_address_byte = '0;
      req_command_byte = '0;
      req_data_byte    = '0;
      req_has_data     = 1'b0;
      words_sent       = 0;
      tx_burst         = 1'b0;
      rx_burst         = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // tone off from reset: idle ticks, all-ones message, start while busy
      send_tick();
      send_tick();
      send_word(OP_START, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
      send_word(OP_START, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
      finish_message(0);
      // all zeros, data byte present but not sent
      run_message(8'h00, 8'h00, 8'h00, 8'hAA, 1'b0, 0);
      write_tone(1'b0);

      // continuous tone: idle ticks carry tone, guard gap before the bits
      write_tone(1'b1);
      send_tick();
      send_word(OP_START, 8'hE0, 8'h10, 8'h38, 8'hF0, 1'b1);
      send_noise_start();
      finish_message(0);
      run_message(8'h00, 8'hFF, 8'h55, 8'hAA, 1'b0, 0);
      send_tick();
      write_tone(1'b0);
      run_message(8'hA5, 8'h5A, 8'h0F, 8'hF0, 1'b1, 0);

      while (words_sent < 1900) begin
         if ($urandom_range(0, 1) == 0)
            write_tone(1'($urandom_range(0, 1)));
         tx_burst   = ($urandom_range(0, 3) == 0);
         idle_ticks = $urandom_range(0, 3);
         repeat (idle_ticks) begin
            if ($urandom_range(0, 4) == 0)
               send_noise_start();
            else
               send_tick();
         end
         if (sb.busy())
            finish_message(20);
         run_message(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                     1'($urandom_range(0, 1)), 20);
      end

      @(negedge clock);
      req_valid = 1'b0;
      bound = 0;
      while (sb.pending() > 0 && bound < 500) begin
         @(posedge clock);
         bound++;
      end
      repeat (8) @(posedge clock);
      if (sb.clean())
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
